/* sv/tvt_pkg.sv */
// tvt_pkg: shared constants, types and fnv hash constants for the token vocabulary table
// no dependencies
`default_nettype none
package tvt_pkg;
    localparam int ENTRIES    = 256;
    localparam int MAX_LEN    = 32;
    localparam int BINS       = 256;
    localparam int KEEP       = MAX_LEN - 1;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int LEN_W      = $clog2(KEEP + 1);
    localparam int POS_W      = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int BIN_W      = $clog2(BINS);
    localparam int CHAR_DEPTH = ENTRIES * KEEP;
    localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam int BMOD       = BINS - 2;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_STR   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    // one result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_index;
        logic [15:0] found_id;
        logic [7:0]  main_bin;
        logic [7:0]  overtone_bin;
    } t_result;
endpackage
`default_nettype wire

/* sv/tvt_hash.sv */
// tvt_hash: fnv-1a byte step with a registered multiply
// depends on tvt_pkg
`default_nettype none
module tvt_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_clear,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_byte,
    output logic             o_busy,
    output logic [31:0]      o_hash
);
    import tvt_pkg::*;

    logic [31:0] r_hash, n_hash;
    logic        r_busy;

    // xor then multiply by prime, one byte a cycle
    always_comb begin
        n_hash = (r_hash ^ {24'd0, i_byte}) * FNV_PRIME;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
            r_busy <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            if (i_clear)
                r_hash <= FNV_BASIS;
            else if (i_take)
                r_hash <= n_hash;
        end
    end

    assign o_busy = r_busy;
    assign o_hash = r_hash;
endmodule
`default_nettype wire

/* sv/tvt_bin.sv */
// tvt_bin: remainder of a 32-bit hash by the bin modulus (254), plus one, registered
// depends on tvt_pkg
`default_nettype none
module tvt_bin (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_value,
    output logic             o_done,
    output logic [7:0]       o_bin
);
    import tvt_pkg::*;

    logic [9:0] w_sum;
    logic [7:0] w_fold;
    logic [6:0] w_r127;
    logic [7:0] r_rem;
    logic       r_done;

    // 254 = 2 * 127: the low bit passes through, the rest reduces mod 127
    // by summing 7-bit digits, since 2^7 is 1 mod 127
    always_comb begin
        w_sum  = 10'(i_value[7:1]) + 10'(i_value[14:8]) + 10'(i_value[21:15]) +
                 10'(i_value[28:22]) + 10'(i_value[31:29]);
        w_fold = 8'(w_sum[6:0]) + 8'(w_sum[9:7]);
        w_r127 = (w_fold >= 8'd127) ? 7'(w_fold - 8'd127) : w_fold[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start)
                r_rem <= {w_r127, i_value[0]};
        end
    end

    assign o_done = r_done;
    assign o_bin  = r_rem + 8'd1;
endmodule
`default_nettype wire

/* sv/tvt_store.sv */
// tvt_store: entry memories (id, length, bins, characters) and the add and search sequencer
// depends on tvt_pkg
`default_nettype none
module tvt_store (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command
    input  wire logic                i_start,
    input  wire logic [1:0]          i_op,
    input  wire logic [15:0]         i_id,
    input  wire logic [tvt_pkg::LEN_W-1:0] i_qlen,
    input  wire logic                i_qover,
    input  wire logic [7:0]          i_pb,
    input  wire logic [7:0]          i_hb,
    // query buffer read port
    output logic [tvt_pkg::POS_W-1:0] o_qaddr,
    input  wire logic [7:0]          i_qdata,
    // result
    output logic                     o_done,
    output tvt_pkg::t_result         o_res
);
    import tvt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_COPY_A, S_COPY_W, S_META, S_ID_RD, S_ID_CMP,
        S_LEN_RD, S_LEN_CMP, S_CH_RD, S_CH_CMP, S_HIT_RD, S_HIT, S_MISS
    } t_state;

    logic [15:0]     m_id   [ENTRIES];
    logic [LEN_W-1:0] m_len [ENTRIES];
    logic [15:0]     m_bins [ENTRIES];
    logic [7:0]      m_char [CHAR_DEPTH];

    t_state          r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_i;
    logic [LEN_W-1:0] r_pos;
    logic [15:0]     r_key;
    logic [LEN_W-1:0] r_qlen;
    logic [15:0]     r_newbins;
    logic [15:0]     r_rd_id;
    logic [LEN_W-1:0] r_rd_len;
    logic [15:0]     r_rd_bins;
    logic [7:0]      r_rd_char;
    logic            r_done;
    t_result         r_res;
    logic [IDX_W-1:0] w_slot;
    logic [CHAR_AW-1:0] w_base;

    assign w_slot  = r_i[IDX_W-1:0];
    assign w_base  = CHAR_AW'(w_slot) * CHAR_AW'(KEEP);
    assign o_qaddr = POS_W'(r_pos);

    // memory ports, registered reads
    always_ff @(posedge i_clk) begin
        r_rd_id   <= m_id[w_slot];
        r_rd_len  <= m_len[w_slot];
        r_rd_bins <= m_bins[w_slot];
        r_rd_char <= m_char[w_base + CHAR_AW'(r_pos)];
        if (r_state == S_COPY_W)
            m_char[w_base + CHAR_AW'(r_pos)] <= i_qdata;
        if (r_state == S_META) begin
            m_id[w_slot]   <= r_key;
            m_len[w_slot]  <= r_qlen;
            m_bins[w_slot] <= r_newbins;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_key     <= i_id;
                        r_qlen    <= i_qlen;
                        r_newbins <= {i_pb, i_hb};
                        r_pos     <= '0;
                        if (i_op == OP_ADD) begin
                            r_i <= r_count;
                            if (r_count == CNT_W'(ENTRIES)) begin
                                r_res  <= '{ST_FULL, 8'd0, 16'd0, 8'd0, 8'd0};
                                r_done <= 1'b1;
                            end else begin
                                r_state <= S_COPY_A;
                            end
                        end else begin
                            r_i <= '0;
                            if (i_op == OP_FIND)
                                r_state <= S_ID_RD;
                            else if (i_qover)
                                r_state <= S_MISS;
                            else
                                r_state <= S_LEN_RD;
                        end
                    end
                end
                // copy query bytes: address cycle, then write cycle
                S_COPY_A: begin
                    if (r_pos == r_qlen)
                        r_state <= S_META;
                    else
                        r_state <= S_COPY_W;
                end
                S_COPY_W: begin
                    r_pos   <= r_pos + LEN_W'(1);
                    r_state <= S_COPY_A;
                end
                S_META: begin
                    r_count <= r_count + CNT_W'(1);
                    r_res   <= '{ST_OK, 8'(w_slot), r_key, r_newbins[15:8],
                                 r_newbins[7:0]};
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                // id search
                S_ID_RD: begin
                    if (r_i == r_count)
                        r_state <= S_MISS;
                    else
                        r_state <= S_ID_CMP;
                end
                S_ID_CMP: begin
                    if (r_rd_id == r_key)
                        r_state <= S_HIT;
                    else begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_ID_RD;
                    end
                end
                // string search: length first, then byte by byte
                S_LEN_RD: begin
                    r_pos <= '0;
                    if (r_i == r_count)
                        r_state <= S_MISS;
                    else
                        r_state <= S_LEN_CMP;
                end
                S_LEN_CMP: begin
                    if (r_rd_len != r_qlen) begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_LEN_RD;
                    end else if (r_qlen == '0)
                        r_state <= S_HIT_RD;
                    else
                        r_state <= S_CH_RD;
                end
                S_CH_RD: begin
                    r_state <= S_CH_CMP;
                end
                S_CH_CMP: begin
                    if (r_rd_char != i_qdata) begin
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_LEN_RD;
                    end else if (r_pos + LEN_W'(1) == r_qlen)
                        r_state <= S_HIT_RD;
                    else begin
                        r_pos   <= r_pos + LEN_W'(1);
                        r_state <= S_CH_RD;
                    end
                end
                S_HIT_RD: begin
                    r_state <= S_HIT;
                end
                S_HIT: begin
                    r_res   <= '{ST_OK, 8'(w_slot), r_rd_id, r_rd_bins[15:8],
                                 r_rd_bins[7:0]};
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_MISS: begin
                    r_res   <= '{ST_NONE, 8'd0, 16'd0, 8'd0, 8'd0};
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

/* sv/token_vocabulary_table_unit.sv */
// token_vocabulary_table_unit: top level of the token vocabulary table
// depends on tvt_pkg, tvt_hash, tvt_bin, tvt_store
//
//  channel | direction | fields
//  in      | input     | op, tok_key, char_byte, last_byte
//  out     | output    | status, entry_index, found_id, main_bin, overtone_bin
//
// string bytes up to a zero byte are collected while the input is open; an id lookup
// walks the stored entries one by one; a string lookup compares each entry's length
// and then its bytes one by one; an add reduces the hash to two bins and then stores
// the bytes. one operation at a time.
// reset is synchronous and clears the count and the stream; memories need no clear.
// o_valid holds with its payload until the beat leaves; in stall waits meanwhile.
`default_nettype none
module token_vocabulary_table_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_tok_key,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_entry_index,
    output logic [15:0]      o_found_id,
    output logic [7:0]       o_main_bin,
    output logic [7:0]       o_overtone_bin
);
    import tvt_pkg::*;

    typedef enum logic [2:0] {S_IN, S_BIN1, S_BIN2, S_RUN, S_OUT} t_state;

    logic [7:0]       m_q [KEEP];
    t_state           r_state;
    logic [LEN_W-1:0] r_qlen;
    logic             r_qover;
    logic             r_ended;
    logic [1:0]       r_op;
    logic [15:0]      r_id;
    logic [7:0]       r_pb;
    logic [7:0]       r_qdata;
    logic             r_valid;
    logic             r_bgo;
    logic             r_sgo;
    t_result          r_out;

    logic             w_acc, w_take, w_clear;
    logic [31:0]      w_hash;
    logic             w_hbusy;
    logic             w_bstart, w_bdone;
    logic [31:0]      w_bval;
    logic [7:0]       w_bin;
    logic             w_sstart, w_sdone;
    t_result          w_sres;
    logic [POS_W-1:0] w_qaddr;

    assign o_stall = (r_state != S_IN);
    assign w_acc   = i_valid && !o_stall;
    // byte collection
    assign w_take  = w_acc && (i_op == OP_ADD || i_op == OP_STR) && !r_ended &&
                     (i_char_byte != 8'd0);
    // an id lookup leaves a partly collected string alone
    assign w_clear = (r_state == S_RUN) && w_sdone && (r_op != OP_FIND);

    tvt_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(w_clear), .i_take(w_take),
        .i_byte(i_char_byte), .o_busy(w_hbusy), .o_hash(w_hash)
    );

    assign w_bval = (r_state == S_BIN1) ? w_hash : {8'd0, w_hash[31:8]};
    tvt_bin u_bin (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_bstart), .i_value(w_bval),
        .o_done(w_bdone), .o_bin(w_bin)
    );

    tvt_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sstart), .i_op(r_op),
        .i_id(r_id), .i_qlen(r_qlen), .i_qover(r_qover), .i_pb(r_pb), .i_hb(w_bin),
        .o_qaddr(w_qaddr), .i_qdata(r_qdata), .o_done(w_sdone), .o_res(w_sres)
    );

    // query buffer, registered read
    always_ff @(posedge i_clk) begin
        r_qdata <= m_q[w_qaddr];
        if (w_take && r_qlen != LEN_W'(KEEP))
            m_q[POS_W'(r_qlen)] <= i_char_byte;
    end

    // the bin unit starts on entry to each bin state
    assign w_bstart = r_bgo;
    assign w_sstart = r_sgo;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_qlen  <= '0;
            r_qover <= 1'b0;
            r_ended <= 1'b0;
            r_valid <= 1'b0;
            r_bgo   <= 1'b0;
            r_sgo   <= 1'b0;
        end else begin
            r_bgo <= 1'b0;
            r_sgo <= 1'b0;
            if (r_valid && !i_stall)
                r_valid <= 1'b0;
            case (r_state)
                S_IN: begin
                    if (w_acc && !w_hbusy) begin
                        if (w_acc && (i_op == OP_ADD || i_op == OP_STR) && !r_ended) begin
                            if (i_char_byte == 8'd0)
                                r_ended <= 1'b1;
                            else if (r_qlen != LEN_W'(KEEP))
                                r_qlen <= r_qlen + LEN_W'(1);
                            else
                                r_qover <= 1'b1;
                        end
                        r_op <= i_op;
                        r_id <= i_tok_key;
                        if (i_op == OP_FIND) begin
                            r_sgo   <= 1'b1;
                            r_state <= S_RUN;
                        end else if (i_op == OP_ADD && i_last_byte) begin
                            r_state <= S_BIN1;
                            r_bgo   <= 1'b1;
                        end else if (i_op == OP_STR && i_last_byte) begin
                            r_sgo   <= 1'b1;
                            r_state <= S_RUN;
                        end
                    end
                end
                S_BIN1: begin
                    if (w_bdone) begin
                        r_pb    <= w_bin;
                        r_bgo   <= 1'b1;
                        r_state <= S_BIN2;
                    end
                end
                S_BIN2: begin
                    if (w_bdone) begin
                        r_sgo   <= 1'b1;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_sdone) begin
                        r_out   <= w_sres;
                        r_valid <= 1'b1;
                        if (r_op != OP_FIND) begin
                            r_qlen  <= '0;
                            r_qover <= 1'b0;
                            r_ended <= 1'b0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_valid || !i_stall)
                        r_state <= S_IN;
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_out.status;
    assign o_entry_index  = r_out.entry_index;
    assign o_found_id     = r_out.found_id;
    assign o_main_bin     = r_out.main_bin;
    assign o_overtone_bin = r_out.overtone_bin;
endmodule
`default_nettype wire

/* sv/tvt_checker.sv */
// tvt_checker: port-level assertions for the token vocabulary table
// depends on tvt_pkg; bound to token_vocabulary_table_unit
`default_nettype none
module tvt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [1:0]  i_op,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_status,
    input wire logic [7:0]  o_entry_index,
    input wire logic [15:0] o_found_id,
    input wire logic [7:0]  o_main_bin,
    input wire logic [7:0]  o_overtone_bin
);
    import tvt_pkg::*;

    // a waiting result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_found_id) && $stable(o_status))
        else $error("result beat changed while stalled");

    // miss and full beats carry zeros
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_found_id == 16'd0 && o_main_bin == 8'd0 &&
        o_entry_index == 8'd0)
        else $error("refused beat has payload");

    // found bins are in range
    a_bins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_main_bin != 8'd0 && o_overtone_bin != 8'd0)
        else $error("bin out of range");

    // an id lookup beat stalls the input for the search
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_op == OP_FIND |=> o_stall)
        else $error("input open during search");
endmodule

bind token_vocabulary_table_unit tvt_checker u_tvt_checker (.*);
`default_nettype wire
